FILE: sv/ili_pkg.sv
// Shared types and codes for the indexed list block.
`default_nettype none
package ili_pkg;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_ERASE  = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        LOP_NONE,
        LOP_APPEND,
        LOP_INSERT,
        LOP_ERASE,
        LOP_READ
    } list_op_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_op_t;

    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 7;

    typedef struct packed {
        action_t                    action;
        logic [POS_W-1:0]           position;
        logic signed [WORD_W-1:0]   value;
    } in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]   read_value;
        status_t                    status;
        logic [COUNT_W-1:0]         count;
    } out_t;

    typedef struct packed {
        status_t  status;
        list_op_t op;
    } decode_t;

endpackage
`default_nettype wire

FILE: sv/ili_cell.sv
// One storage cell of the list chain: holds, loads or takes a neighbor's word.
`default_nettype none
module ili_cell (
    input  wire logic                              aclk,
    input  wire ili_pkg::cell_op_t                 op,
    input  wire logic signed [ili_pkg::WORD_W-1:0] load_value,
    input  wire logic signed [ili_pkg::WORD_W-1:0] left_data,
    input  wire logic signed [ili_pkg::WORD_W-1:0] right_data,
    output logic signed [ili_pkg::WORD_W-1:0]      data
);

    logic signed [ili_pkg::WORD_W-1:0] data_reg;
    logic signed [ili_pkg::WORD_W-1:0] data_next;

    always_comb begin
        case (op)
            ili_pkg::CELL_LOAD:       data_next = load_value;
            ili_pkg::CELL_FROM_LEFT:  data_next = left_data;
            ili_pkg::CELL_FROM_RIGHT: data_next = right_data;
            default:                  data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

FILE: sv/ili_ctrl.sv
// Request decode: range and full checks, list operation, target slot, new count.
`default_nettype none
module ili_ctrl #(
    parameter int CAPACITY = 64
) (
    input  wire ili_pkg::action_t           action,
    input  wire logic [ili_pkg::POS_W-1:0]  position,
    input  wire logic [$clog2(CAPACITY+1)-1:0] count,
    output ili_pkg::decode_t                dec,
    output logic [((($clog2(CAPACITY+1)) > ili_pkg::POS_W) ?
                   $clog2(CAPACITY+1) : ili_pkg::POS_W)-1:0] target,
    output logic [$clog2(CAPACITY+1)-1:0]   count_next
);

    localparam int CW   = $clog2(CAPACITY+1);
    localparam int CMPW = (CW > ili_pkg::POS_W) ? CW : ili_pkg::POS_W;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            full;

    assign pos_ext = CMPW'(position);
    assign cnt_ext = CMPW'(count);
    assign full    = (count == CW'(CAPACITY));

    always_comb begin
        dec.status = ili_pkg::ST_OK;
        dec.op     = ili_pkg::LOP_NONE;
        target     = pos_ext;
        case (action)
            ili_pkg::ACT_APPEND: begin
                target = cnt_ext;
                if (full) begin
                    dec.status = ili_pkg::ST_FULL;
                end else begin
                    dec.op = ili_pkg::LOP_APPEND;
                end
            end
            ili_pkg::ACT_INSERT: begin
                // position check wins over the full check
                if (pos_ext > cnt_ext) begin
                    dec.status = ili_pkg::ST_RANGE;
                end else if (full) begin
                    dec.status = ili_pkg::ST_FULL;
                end else begin
                    dec.op = ili_pkg::LOP_INSERT;
                end
            end
            ili_pkg::ACT_ERASE: begin
                if (pos_ext >= cnt_ext) begin
                    dec.status = ili_pkg::ST_RANGE;
                end else begin
                    dec.op = ili_pkg::LOP_ERASE;
                end
            end
            default: begin
                if (pos_ext >= cnt_ext) begin
                    dec.status = ili_pkg::ST_RANGE;
                end else begin
                    dec.op = ili_pkg::LOP_READ;
                end
            end
        endcase
    end

    always_comb begin
        case (dec.op)
            ili_pkg::LOP_APPEND,
            ili_pkg::LOP_INSERT: count_next = count + CW'(1);
            ili_pkg::LOP_ERASE:  count_next = count - CW'(1);
            default:             count_next = count;
        endcase
    end

endmodule
`default_nettype wire

FILE: sv/indexed_list_insert_erase.sv
// Indexed list: a chain of CAPACITY word cells that shift up or down on insert/erase.
// The result is registered and appears in the cycle after the request transaction.
// Throughput: one request per cycle unless the output stalls; every cell moves in the
// same cycle, and the count register and the cell contents carry state between requests.
// Reset: synchronous active-low aresetn clears the count and output valid;
// cell contents are not reset and are only read once written.
`default_nettype none
module indexed_list_insert_erase #(
    parameter int CAPACITY = 64
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire ili_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output ili_pkg::out_t      m_data
);

    localparam int CW   = $clog2(CAPACITY+1);
    localparam int CMPW = (CW > ili_pkg::POS_W) ? CW : ili_pkg::POS_W;
    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    ili_pkg::out_t    m_data_reg;
    ili_pkg::out_t    m_data_next;

    ili_pkg::decode_t dec;
    logic [CMPW-1:0]  target;
    logic [CW-1:0]    count_calc;
    logic             s_fire;
    logic [IW-1:0]    rd_idx;

    logic signed [ili_pkg::WORD_W-1:0] cell_data [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    ili_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .action     (s_data.action),
        .position   (s_data.position),
        .count      (count_reg),
        .dec        (dec),
        .target     (target),
        .count_next (count_calc)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CMPW-1:0] IDX = CMPW'(i);
        ili_pkg::cell_op_t                 op;
        logic signed [ili_pkg::WORD_W-1:0] left_data;
        logic signed [ili_pkg::WORD_W-1:0] right_data;

        if (i == 0) begin : g_first
            assign left_data = s_data.value;
        end else begin : g_mid_l
            assign left_data = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_data = cell_data[i];
        end else begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        always_comb begin
            op = ili_pkg::CELL_HOLD;
            if (s_fire) begin
                case (dec.op)
                    ili_pkg::LOP_APPEND: begin
                        if (IDX == target) op = ili_pkg::CELL_LOAD;
                    end
                    ili_pkg::LOP_INSERT: begin
                        if (IDX == target) begin
                            op = ili_pkg::CELL_LOAD;
                        end else if (IDX > target) begin
                            op = ili_pkg::CELL_FROM_LEFT;
                        end
                    end
                    ili_pkg::LOP_ERASE: begin
                        if (IDX >= target) op = ili_pkg::CELL_FROM_RIGHT;
                    end
                    default: op = ili_pkg::CELL_HOLD;
                endcase
            end
        end

        ili_cell u_cell (
            .aclk       (aclk),
            .op         (op),
            .load_value (s_data.value),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    // a successful read has position below count, so the low bits index a cell
    assign rd_idx = target[IW-1:0];

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire) begin
            count_next             = count_calc;
            m_valid_next           = 1'b1;
            m_data_next.status     = dec.status;
            m_data_next.count      = ili_pkg::COUNT_W'(count_calc);
            m_data_next.read_value = (dec.op == ili_pkg::LOP_READ) ? cell_data[rd_idx]
                                                                    : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_append_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && dec.op == ili_pkg::LOP_APPEND)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("append did not grow the list");

    a_reject_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && dec.status != ili_pkg::ST_OK)
        |=> count_reg == $past(count_reg))
        else $error("rejected request changed the count");

    a_reject_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != ili_pkg::ST_OK) |-> m_data.read_value == '0)
        else $error("rejected request returned a nonzero word");
`endif

endmodule
`default_nettype wire

FILE: verif/tb_indexed_list_insert_erase.sv
// Self-checking testbench for the indexed list: random bursts and stalls on both handshakes.
module tb_indexed_list_insert_erase;

    localparam int LIST_CAP       = 64;
    localparam int RANDOM_REQS    = 1000;
    localparam int HOLD_START     = 600;
    localparam int HOLD_LEN       = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 4;

    logic          aclk    = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    ili_pkg::in_t  s_data  = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    ili_pkg::out_t m_data;

    indexed_list_insert_erase #(.CAPACITY(LIST_CAP)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Requests waiting to be sent and results the list should return, oldest first.
    ili_pkg::in_t  pending_reqs[$];
    ili_pkg::out_t expected_results[$];

    // Shadow copy of the list.
    logic signed [ili_pkg::WORD_W-1:0] list_cells [LIST_CAP];
    int list_len = 0;
    int longest_len = 0;

    int errors = 0;
    int reqs_sent = 0;
    int results_seen = 0;
    int ok_seen = 0;
    int range_seen = 0;
    int full_seen = 0;

    // Length the list will have once the queued requests are done; steers positions.
    int gen_len = 0;

    function automatic ili_pkg::out_t predict_list_op(ili_pkg::in_t req);
        ili_pkg::out_t res;
        int            p;
        res.read_value = '0;
        res.status     = ili_pkg::ST_OK;
        p = int'(req.position);
        case (req.action)
            ili_pkg::ACT_APPEND: begin
                if (list_len >= LIST_CAP) begin
                    res.status = ili_pkg::ST_FULL;
                end else begin
                    list_cells[list_len] = req.value;
                    list_len++;
                end
            end
            ili_pkg::ACT_INSERT: begin
                // position check wins over the full check
                if (p > list_len) begin
                    res.status = ili_pkg::ST_RANGE;
                end else if (list_len >= LIST_CAP) begin
                    res.status = ili_pkg::ST_FULL;
                end else begin
                    for (int i = list_len; i > p; i--) list_cells[i] = list_cells[i-1];
                    list_cells[p] = req.value;
                    list_len++;
                end
            end
            ili_pkg::ACT_ERASE: begin
                if (p >= list_len) begin
                    res.status = ili_pkg::ST_RANGE;
                end else begin
                    for (int i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
                    list_len--;
                end
            end
            default: begin
                if (p >= list_len) res.status = ili_pkg::ST_RANGE;
                else res.read_value = list_cells[p];
            end
        endcase
        res.count = ili_pkg::COUNT_W'(list_len);
        if (list_len > longest_len) longest_len = list_len;
        return res;
    endfunction

    task automatic add_req(ili_pkg::action_t a, int pos, logic [ili_pkg::WORD_W-1:0] v);
        ili_pkg::in_t r;
        r.action   = a;
        r.position = ili_pkg::POS_W'(pos);
        r.value    = v;
        pending_reqs.insert(pending_reqs.size(), r);
        case (a)
            ili_pkg::ACT_APPEND: if (gen_len < LIST_CAP) gen_len++;
            ili_pkg::ACT_INSERT: if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
            ili_pkg::ACT_ERASE:  if (pos < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    // kind 0 grows the list, 1 shrinks it, 2 mixes all four actions
    function automatic ili_pkg::action_t pick_action(int kind);
        int r;
        r = $urandom_range(0, 99);
        case (kind)
            0: begin
                if (r < 40) return ili_pkg::ACT_APPEND;
                else if (r < 80) return ili_pkg::ACT_INSERT;
                else if (r < 90) return ili_pkg::ACT_ERASE;
                else return ili_pkg::ACT_READ;
            end
            1: begin
                if (r < 10) return ili_pkg::ACT_APPEND;
                else if (r < 20) return ili_pkg::ACT_INSERT;
                else if (r < 75) return ili_pkg::ACT_ERASE;
                else return ili_pkg::ACT_READ;
            end
            default: begin
                if (r < 20) return ili_pkg::ACT_APPEND;
                else if (r < 45) return ili_pkg::ACT_INSERT;
                else if (r < 70) return ili_pkg::ACT_ERASE;
                else return ili_pkg::ACT_READ;
            end
        endcase
    endfunction

    function automatic logic [ili_pkg::WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 32'h8000_0000;
        if (r == 1) return 32'h7FFF_FFFF;
        if (r == 2) return 32'hFFFF_FFFF;
        if (r == 3) return 32'h0000_0000;
        return $urandom;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                s_data  <= pending_reqs.pop_front();
                s_valid <= 1'b1;
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 60);
                    gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: a random stall pattern, redrawn at intervals, plus one long hold-off.
    int rx_cycle = 0;
    int hold_left = 0;
    logic [15:0] rx_pat = 16'hFFFF;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle = rx_cycle + 1;
            if (rx_cycle == HOLD_START) hold_left = HOLD_LEN;
            if (rx_cycle % 64 == 0) rx_pat = ($urandom_range(0, 9) < 3) ? 16'hFFFF : 16'($urandom);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= rx_pat[rx_cycle % 16];
            end
        end
    end

    // Check results first, then predict the request taken at this edge.
    always @(posedge aclk) begin
        ili_pkg::out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result read_value=%0d status=%0d count=%0d",
                             $time, m_data.read_value, m_data.status, m_data.count);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d got %0d",
                                 $time, want.read_value, m_data.read_value);
                        errors++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, m_data.status);
                        errors++;
                    end
                    if (m_data.count !== want.count) begin
                        $display("%0t: count expected %0d got %0d",
                                 $time, want.count, m_data.count);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                reqs_sent++;
                want = predict_list_op(s_data);
                case (want.status)
                    ili_pkg::ST_OK:    ok_seen++;
                    ili_pkg::ST_RANGE: range_seen++;
                    default:           full_seen++;
                endcase
                expected_results.insert(expected_results.size(), want);
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("indexed_list_insert_erase: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int made;
        int kind;
        int seg_len;
        int pos;
        ili_pkg::action_t a;

        // empty list: reads, erases and an insert past the end all miss
        add_req(ili_pkg::ACT_READ,   0, 32'h1234_5678);
        add_req(ili_pkg::ACT_ERASE,  0, 32'h0);
        add_req(ili_pkg::ACT_INSERT, 1, 32'h1);
        add_req(ili_pkg::ACT_INSERT, 0, 32'h7FFF_FFFF);
        add_req(ili_pkg::ACT_APPEND, 127, 32'h8000_0000);  // position ignored on append
        add_req(ili_pkg::ACT_APPEND, 0, 32'hFFFF_FFFF);
        add_req(ili_pkg::ACT_INSERT, 3, 32'h0);            // insert at the end
        add_req(ili_pkg::ACT_INSERT, 127, 32'h2);          // insert past the end
        add_req(ili_pkg::ACT_INSERT, 1, 32'h5555_5555);
        add_req(ili_pkg::ACT_READ,   0, 32'hFFFF_FFFF);
        add_req(ili_pkg::ACT_READ,   4, 32'h0);
        add_req(ili_pkg::ACT_READ,   5, 32'h0);            // one past the end
        add_req(ili_pkg::ACT_READ,   127, 32'h0);
        add_req(ili_pkg::ACT_ERASE,  4, 32'hAAAA_AAAA);    // last
        add_req(ili_pkg::ACT_ERASE,  0, 32'h0);            // first
        add_req(ili_pkg::ACT_ERASE,  1, 32'h0);            // middle
        add_req(ili_pkg::ACT_ERASE,  127, 32'h0);
        add_req(ili_pkg::ACT_ERASE,  2, 32'h0);            // one past the end
        add_req(ili_pkg::ACT_APPEND, 0, 32'hAAAA_AAAA);
        add_req(ili_pkg::ACT_READ,   0, 32'h0);
        add_req(ili_pkg::ACT_READ,   1, 32'h0);
        add_req(ili_pkg::ACT_READ,   2, 32'h0);

        // random segments that grow to full, shrink to empty or wander
        made = 0;
        while (made < RANDOM_REQS) begin
            kind = $urandom_range(0, 2);
            seg_len = $urandom_range(40, 150);
            for (int k = 0; k < seg_len; k++) begin
                a = pick_action(kind);
                if ($urandom_range(0, 99) < 15) pos = $urandom_range(0, 127);
                else pos = $urandom_range(0, gen_len);
                add_req(a, pos, pick_word());
                made++;
            end
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_reqs.size() != 0 || s_valid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d requests, %0d results: %0d ok, %0d out of range, %0d full",
                 reqs_sent, results_seen, ok_seen, range_seen, full_seen);
        $display("longest list %0d of %0d, one receiver hold-off of %0d cycles",
                 longest_len, LIST_CAP, HOLD_LEN);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("indexed_list_insert_erase: match");
        end else begin
            $display("indexed_list_insert_erase: mismatch");
        end
        $finish;
    end

endmodule
